[hw/rtl/nsl_pkg.sv]
// nsl_pkg: shared types, constants and Q24.24 arithmetic helpers
// for the slope limiter pipeline; no dependencies
package nsl_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int QF         = 24;
  localparam int QW         = 2 * QF;
  localparam int WW         = QW + 4;
  localparam int TQ_SHL     = (FRAC_BITS <= QF) ? (QF - FRAC_BITS) : 0;
  localparam int TQ_SHR     = (FRAC_BITS > QF) ? (FRAC_BITS - QF) : 0;
  localparam int OUT_W      = 18;
  localparam int OUT_FRAC   = 16;
  localparam int DIV_STEPS  = OUT_W;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [WW-1:0] w_t;
  typedef logic [2:0]           ord_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam w_t W_QMAX = WW'(Q_MAX);
  localparam w_t W_QMIN = WW'(Q_MIN);
  localparam logic [QW+1:0] M_OVF    = {2'b01, {QW{1'b0}}};
  localparam logic [QW+1:0] M_NEGLIM = {3'b001, {(QW-1){1'b0}}};
  localparam logic [QW+1:0] M_POSLIM = {3'b000, {(QW-1){1'b1}}};

  localparam logic [OUT_W-1:0] OUT_MAX = '1;
  localparam logic [OUT_W-1:0] OUT_ONE = {2'b01, {OUT_FRAC{1'b0}}};

  localparam ord_t ORD_2 = 3'd2;
  localparam ord_t ORD_3 = 3'd3;
  localparam ord_t ORD_4 = 3'd4;
  localparam ord_t ORD_5 = 3'd5;
  localparam ord_t ORD_RESET = ORD_2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] cell_value;
    logic signed [DATA_WIDTH-1:0] stencil_min;
    logic signed [DATA_WIDTH-1:0] stencil_max;
    logic signed [DATA_WIDTH-1:0] face_difference;
    logic [DATA_WIDTH-2:0]        volume_eps;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] limiter_value;
    logic             saturated;
  } out_item_t;

  // clamp a widened value into Q24.24
  function automatic q_t sat_q(w_t v);
    if (v > W_QMAX) return Q_MAX;
    if (v < W_QMIN) return Q_MIN;
    return QW'(v);
  endfunction

  // magnitude, widened so that the most negative value stays exact
  function automatic w_t wabs(q_t x);
    if (x[QW-1]) return -WW'(x);
    return WW'(x);
  endfunction

  // input format to Q24.24, floor on right shift, saturating
  function automatic q_t to_q(logic signed [DATA_WIDTH-1:0] v);
    logic signed [127:0] w;
    w = 128'(v);
    w = (w <<< TQ_SHL) >>> TQ_SHR;
    if (w > 128'(Q_MAX)) return Q_MAX;
    if (w < 128'(Q_MIN)) return Q_MIN;
    return QW'(w);
  endfunction

  // signed Q24.24 product on magnitudes, truncated, saturating
  function automatic q_t qmul(q_t x, q_t y);
    logic            neg;
    logic [QW-1:0]   ux;
    logic [QW-1:0]   uy;
    logic [QF-1:0]   xh;
    logic [QF-1:0]   xl;
    logic [QF-1:0]   yh;
    logic [QF-1:0]   yl;
    logic [QW-1:0]   hh;
    logic [QW-1:0]   hl;
    logic [QW-1:0]   lh;
    logic [QW-1:0]   ll;
    logic [QW+1:0]   m;
    neg = x[QW-1] ^ y[QW-1];
    ux = x[QW-1] ? QW'(-x) : QW'(x);
    uy = y[QW-1] ? QW'(-y) : QW'(y);
    {xh, xl} = ux;
    {yh, yl} = uy;
    hh = xh * yh;
    hl = xh * yl;
    lh = xl * yh;
    ll = xl * yl;
    if (hh[QW-1:QF] != '0) begin
      m = M_OVF;
    end else begin
      m = (QW+2)'({hh[QF-1:0], {QF{1'b0}}}) + (QW+2)'(hl) + (QW+2)'(lh)
          + (QW+2)'(ll[QW-1:QF]);
    end
    if (neg) begin
      if (m > M_NEGLIM) return Q_MIN;
      return QW'((QW+2)'(0) - m);
    end
    if (m > M_POSLIM) return Q_MAX;
    return QW'(m);
  endfunction

endpackage

[hw/rtl/nishikawa_slope_limiter.sv]
// nishikawa_slope_limiter: top level, one face limiter value per item
// depends on nsl_pkg for types, constants and Q24.24 helpers
//
// streaming slope limiter: takes one face item per clock and returns one
// limiter item for it, in order. the work runs through 29 register stages:
// input conversion, the power and Sp multiplier chains (one Q24.24 product
// level per stage), num/den assembly, a classify stage for the early exit and
// the zero, negative and overrange cases, then a restoring divider that
// retires one quotient bit per stage (18 stages), then the output register.
// the pipe takes one item per cycle while out_ready is high and no cfg write
// is pending. each stage holds only while the stage after it is full and
// stalled, so bubbles are squeezed out and input is still taken while a
// result waits at the output. the order register (cfg port, values below 2
// act as 2, above 5 as 5) is written only with the pipe empty: cfg_ready is
// low while any stage holds an item, and a pending cfg write holds the input
// off so the pipe drains before the new order takes effect.
module nishikawa_slope_limiter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nsl_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nsl_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  nsl_pkg::ord_t     cfg_data
);
  import nsl_pkg::*;

  localparam int NA = 9;                 // arithmetic stages
  localparam int NS = NA + DIV_STEPS + 2; // plus classify, divider, output

  // stage valid bits and advance enables
  logic [NS-1:0] sv;
  logic [NS-1:0] en;

  // order register and its clamped form
  ord_t ord_reg;
  ord_t ord_p;

  // order changes only with nothing in flight
  assign cfg_ready = (sv == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_reg <= ORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ord_reg <= cfg_data;
    end
  end

  always_comb begin
    if (ord_reg < ORD_2) begin
      ord_p = ORD_2;
    end else if (ord_reg > ORD_5) begin
      ord_p = ORD_5;
    end else begin
      ord_p = ord_reg;
    end
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NS-1] = !sv[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !sv[k] || en[k+1];
    end
  end

  // a pending cfg write blocks new items so the pipe can drain
  assign in_ready  = en[0] && !cfg_valid;
  assign out_valid = sv[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      if (en[0]) begin
        sv[0] <= in_valid && in_ready;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          sv[k] <= sv[k-1];
        end
      end
    end
  end

  // stage 0: inputs to Q24.24
  q_t s0_xc, s0_qmn, s0_qmx, s0_qd, s0_eps;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_xc  <= to_q(in_data.cell_value);
      s0_qmn <= to_q(in_data.stencil_min);
      s0_qmx <= to_q(in_data.stencil_max);
      s0_qd  <= to_q(in_data.face_difference);
      s0_eps <= to_q({1'b0, in_data.volume_eps});
    end
  end

  // stage 1: delp toward max or min, a = |delp|, b = |diff| plus one lsb
  q_t s1_delp, s1_a, s1_b, s1_eps;
  q_t delp_c;

  assign delp_c = sat_q(WW'(s0_qd[QW-1] ? s0_qmn : s0_qmx) - WW'(s0_xc));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_delp <= delp_c;
      s1_a    <= sat_q(wabs(delp_c));
      s1_b    <= sat_q(wabs(s0_qd) + w_t'(1));
      s1_eps  <= s0_eps;
    end
  end

  // stage 2: early exit test, first products
  q_t   s2_a, s2_b, s2_b2, s2_delp, s2_eps, s2_aa, s2_bb, s2_dp2, s2_d;
  logic s2_early;
  q_t   b2_c;

  assign b2_c = sat_q(WW'(s1_b) <<< 1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_early <= WW'(s1_a) > (WW'(s1_b) <<< 1);
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_b2    <= b2_c;
      s2_delp  <= s1_delp;
      s2_eps   <= s1_eps;
      s2_aa    <= qmul(s1_a, s1_a);
      s2_bb    <= qmul(s1_b, s1_b);
      s2_dp2   <= qmul(s1_delp, s1_delp);
      s2_d     <= sat_q(WW'(s1_a) - WW'((ord_p == ORD_5) ? s1_b : b2_c));
    end
  end

  // stage 3: cubes, 2b*(a - x), scaled b^2
  q_t   s3_a, s3_b, s3_b2, s3_delp, s3_eps, s3_aa, s3_a3, s3_dp2, s3_dp3;
  q_t   s3_t, s3_spl, s3_e8;
  logic s3_early;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_early <= s2_early;
      s3_a     <= s2_a;
      s3_b     <= s2_b;
      s3_b2    <= s2_b2;
      s3_delp  <= s2_delp;
      s3_eps   <= s2_eps;
      s3_aa    <= s2_aa;
      s3_dp2   <= s2_dp2;
      s3_a3    <= qmul(s2_aa, s2_a);
      s3_dp3   <= qmul(s2_dp2, s2_delp);
      s3_t     <= qmul(s2_b2, s2_d);
      s3_spl   <= sat_q((ord_p == ORD_2) ? (WW'(s2_bb) <<< 1) : (WW'(s2_bb) <<< 2));
      s3_e8    <= sat_q(WW'(s2_bb) <<< 3);
    end
  end

  // stage 4: fourth powers, a^2 - 2b*(a - x)
  q_t   s4_a, s4_b, s4_b2, s4_delp, s4_eps, s4_aa, s4_a3, s4_a4;
  q_t   s4_dp2, s4_dp3, s4_dp4, s4_u, s4_spl, s4_e8;
  logic s4_early;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_early <= s3_early;
      s4_a     <= s3_a;
      s4_b     <= s3_b;
      s4_b2    <= s3_b2;
      s4_delp  <= s3_delp;
      s4_eps   <= s3_eps;
      s4_aa    <= s3_aa;
      s4_a3    <= s3_a3;
      s4_dp2   <= s3_dp2;
      s4_dp3   <= s3_dp3;
      s4_spl   <= s3_spl;
      s4_e8    <= s3_e8;
      s4_a4    <= qmul(s3_a3, s3_a);
      s4_dp4   <= qmul(s3_dp3, s3_delp);
      s4_u     <= sat_q(WW'(s3_aa) - WW'(s3_t));
    end
  end

  // stage 5: a^p, Sp and delp^(p-1) picked by order
  q_t   s5_a, s5_b, s5_eps, s5_apow, s5_sp, s5_dpow;
  logic s5_early;
  q_t   spm_c;

  assign spm_c = qmul((ord_p == ORD_4) ? s4_b2 : s4_e8, s4_u);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_early <= s4_early;
      s5_a     <= s4_a;
      s5_b     <= s4_b;
      s5_eps   <= s4_eps;
      case (ord_p)
        ORD_2: begin
          s5_apow <= s4_aa;
          s5_sp   <= s4_spl;
          s5_dpow <= s4_delp;
        end
        ORD_3: begin
          s5_apow <= s4_a3;
          s5_sp   <= s4_spl;
          s5_dpow <= s4_dp2;
        end
        ORD_4: begin
          s5_apow <= s4_a4;
          s5_sp   <= spm_c;
          s5_dpow <= s4_dp3;
        end
        default: begin
          s5_apow <= qmul(s4_a4, s4_a);
          s5_sp   <= spm_c;
          s5_dpow <= s4_dp4;
        end
      endcase
    end
  end

  // stage 6: fun1, a*Sp, delp^(p-1) + Sp
  q_t   s6_b, s6_fun1, s6_asp, s6_s2;
  logic s6_early;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_early <= s5_early;
      s6_b     <= s5_b;
      s6_fun1  <= sat_q(WW'(s5_apow) + WW'(s5_eps));
      s6_asp   <= qmul(s5_a, s5_sp);
      s6_s2    <= sat_q(WW'(s5_dpow) + WW'(s5_sp));
    end
  end

  // stage 7: num, b*(...)
  q_t   s7_fun1, s7_num, s7_bs;
  logic s7_early;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_early <= s6_early;
      s7_fun1  <= s6_fun1;
      s7_num   <= sat_q(WW'(s6_fun1) + WW'(s6_asp));
      s7_bs    <= qmul(s6_b, s6_s2);
    end
  end

  // stage 8: den
  q_t   s8_num, s8_den;
  logic s8_early;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_early <= s7_early;
      s8_num   <= s7_num;
      s8_den   <= sat_q(WW'(s7_fun1) + WW'(s7_bs));
    end
  end

  // divider pipe: index 0 is the classify stage, index j+1 follows step j
  logic [QW:0]       dv_r   [DIV_STEPS+1];
  logic [QW-1:0]     dv_d   [DIV_STEPS+1];
  logic [1:0]        dv_lo  [DIV_STEPS+1];
  logic [OUT_W-1:0]  dv_q   [DIV_STEPS+1];
  logic              dv_fix [DIV_STEPS+1];
  logic [OUT_W-1:0]  dv_fval[DIV_STEPS+1];
  logic              dv_fsat[DIV_STEPS+1];

  logic [QW-1:0] un_c, ud_c;

  assign un_c = s8_num[QW-1] ? QW'(-s8_num) : QW'(s8_num);
  assign ud_c = s8_den[QW-1] ? QW'(-s8_den) : QW'(s8_den);

  // stage 9: special cases; the quotient overflows when |num| >= 4|den|
  always_ff @(posedge clk) begin
    if (en[NA]) begin
      dv_r[0]  <= (QW+1)'(un_c >> 2);
      dv_d[0]  <= ud_c;
      dv_lo[0] <= un_c[1:0];
      dv_q[0]  <= '0;
      if (s8_early) begin
        dv_fix[0]  <= 1'b1;
        dv_fval[0] <= OUT_ONE;
        dv_fsat[0] <= 1'b0;
      end else if (s8_den == '0) begin
        dv_fix[0]  <= 1'b1;
        dv_fval[0] <= (!s8_num[QW-1] && s8_num != '0) ? OUT_MAX : '0;
        dv_fsat[0] <= 1'b1;
      end else if (s8_num == '0 || (s8_num[QW-1] != s8_den[QW-1])) begin
        dv_fix[0]  <= 1'b1;
        dv_fval[0] <= '0;
        dv_fsat[0] <= 1'b0;
      end else if ((QW+2)'(un_c) >= ((QW+2)'(ud_c) << 2)) begin
        dv_fix[0]  <= 1'b1;
        dv_fval[0] <= OUT_MAX;
        dv_fsat[0] <= 1'b1;
      end else begin
        dv_fix[0]  <= 1'b0;
        dv_fval[0] <= '0;
        dv_fsat[0] <= 1'b0;
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic          bit_in;
    logic [QW:0]   rs;
    logic          qbit;

    if (j == 0) begin : g_b1
      assign bit_in = dv_lo[j][1];
    end else if (j == 1) begin : g_b0
      assign bit_in = dv_lo[j][0];
    end else begin : g_bz
      assign bit_in = 1'b0;
    end

    assign rs   = {dv_r[j][QW-1:0], bit_in};
    assign qbit = rs >= (QW+1)'(dv_d[j]);

    always_ff @(posedge clk) begin
      if (en[NA+1+j]) begin
        dv_r[j+1]    <= qbit ? (rs - (QW+1)'(dv_d[j])) : rs;
        dv_d[j+1]    <= dv_d[j];
        dv_lo[j+1]   <= dv_lo[j];
        dv_q[j+1]    <= {dv_q[j][OUT_W-2:0], qbit};
        dv_fix[j+1]  <= dv_fix[j];
        dv_fval[j+1] <= dv_fval[j];
        dv_fsat[j+1] <= dv_fsat[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (dv_fix[DIV_STEPS]) begin
        out_data.limiter_value <= dv_fval[DIV_STEPS];
        out_data.saturated     <= dv_fsat[DIV_STEPS];
      end else begin
        out_data.limiter_value <= dv_q[DIV_STEPS];
        out_data.saturated     <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a stalled stage in front of the output keeps its item
  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    sv[NS-2] && !en[NS-2] |=> sv[NS-2])
    else $error("stalled item dropped before output");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    sv[NS-2] && !dv_fix[DIV_STEPS] |-> dv_r[DIV_STEPS] < (QW+1)'(dv_d[DIV_STEPS]))
    else $error("divider remainder out of range");

  // a saturated result is pinned at full scale or zero
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.limiter_value == OUT_MAX || out_data.limiter_value == '0))
    else $error("saturated item with partial value");

  // clamped order always lands in the supported range
  a_ord_range: assert property (@(posedge clk) disable iff (rst)
    ord_p >= ORD_2 && ord_p <= ORD_5)
    else $error("order clamp out of range");
`endif

endmodule
